@@ rtl/tlps_pkg.sv @@
// shared types and constants for the traffic light pedestrian sequencer
package tlps_pkg;

  localparam int unsigned AddrW = 4;

  localparam logic [1:0] RegPhaseTicks = 2'd0;
  localparam logic [1:0] RegBlinkTicks = 2'd1;
  localparam logic [1:0] RegBlinkCount = 2'd2;

  localparam logic [15:0] PhaseTicksRst = 16'd5000;
  localparam logic [15:0] BlinkTicksRst = 16'd500;
  localparam logic [7:0]  BlinkCountRst = 8'd10;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [15:0] blink_ticks;
    logic [7:0]  blink_count;
  } cfg_t;

  typedef struct packed {
    logic       car_green;
    logic       car_yellow;
    logic       car_red;
    logic       walk_green;
    logic       walk_yellow;
    logic       walk_red;
    logic [2:0] phase;
  } res_t;

endpackage

@@ rtl/tlps_req_if.sv @@
// request channel carrying the pedestrian button flag of one tick
interface tlps_req_if;
  logic valid;
  logic ready;
  logic button_press;

  modport source (output valid, button_press, input ready);
  modport sink (input valid, button_press, output ready);
endinterface

@@ rtl/tlps_rsp_if.sv @@
// result channel carrying the lamp states and phase of one tick
interface tlps_rsp_if;
  logic       valid;
  logic       ready;
  logic       car_green;
  logic       car_yellow;
  logic       car_red;
  logic       walk_green;
  logic       walk_yellow;
  logic       walk_red;
  logic [2:0] phase;

  modport source (output valid, car_green, car_yellow, car_red, walk_green, walk_yellow,
                  walk_red, phase, input ready);
  modport sink (input valid, car_green, car_yellow, car_red, walk_green, walk_yellow,
                walk_red, phase, output ready);
endinterface

@@ rtl/traffic_light_pedestrian_sequencer_core.sv @@
// top level of the traffic light sequencer with pedestrian button
// usage:
//   req_i carries one request per time tick with the pedestrian button flag;
//   rsp_o returns one result per request: six lamp bits and the phase code
//   both channels use valid/ready, a transfer happens when both are high
//   an accepted request goes into the input register, then the phase logic
//   loads its result into the result register once that register is free
//   throughput is one request per cycle while rsp_o.ready stays high
//   when the receiver stalls, the result register holds its item and the
//   input register can still take one more request before req_i.ready drops
//   the apb port sets phase_ticks (0x0), blink_ticks (0x4) and blink_count (0x8);
//   write it only while no request is in flight
//   reset clears both pipeline valids, puts the sequencer in the car go phase
//   with zero counters, and loads the default timing 5000 / 500 / 10
module traffic_light_pedestrian_sequencer_core import tlps_pkg::*; #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tlps_req_if.sink         req_i,
  tlps_rsp_if.source       rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg;
  res_t res;
  res_t out_res_q;
  logic s1_valid_q, s1_press_q, out_valid_q;
  logic out_free, step;

  tlps_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tlps_seq_core #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_seq_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .press_i (s1_press_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign step        = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) s1_valid_q <= req_i.valid;
      if (out_free) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) s1_press_q <= req_i.button_press;
    if (step) out_res_q <= res;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.car_green   = out_res_q.car_green;
  assign rsp_o.car_yellow  = out_res_q.car_yellow;
  assign rsp_o.car_red     = out_res_q.car_red;
  assign rsp_o.walk_green  = out_res_q.walk_green;
  assign rsp_o.walk_yellow = out_res_q.walk_yellow;
  assign rsp_o.walk_red    = out_res_q.walk_red;
  assign rsp_o.phase       = out_res_q.phase;

  // car green and car red never lit together
  a_car_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.car_green && rsp_o.car_red))
    else $error("car green and red lit together");

  // walk green only while cars see red and walk red is dark
  a_walk_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.walk_green) |-> (rsp_o.car_red && !rsp_o.walk_red))
    else $error("walk green without car red");

  // a pending request with a free result slot lands in the result register
  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("result lost after step");

  // input side is open whenever the pipeline holds nothing
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s1_valid_q && !out_valid_q) |-> req_i.ready)
    else $error("ready low with empty pipeline");

endmodule

@@ rtl/tlps_cfg_regs.sv @@
// apb configuration registers for timing of phases and blinking
module tlps_cfg_regs import tlps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_ticks <= PhaseTicksRst;
      cfg_q.blink_ticks <= BlinkTicksRst;
      cfg_q.blink_count <= BlinkCountRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegPhaseTicks: cfg_q.phase_ticks <= pwdata[15:0];
        RegBlinkTicks: cfg_q.blink_ticks <= pwdata[15:0];
        RegBlinkCount: cfg_q.blink_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegPhaseTicks: prdata = {16'd0, cfg_q.phase_ticks};
      RegBlinkTicks: prdata = {16'd0, cfg_q.blink_ticks};
      RegBlinkCount: prdata = {24'd0, cfg_q.blink_count};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/tlps_seq_core.sv @@
// phase state machine, tick and blink counters and lamp decode
module tlps_seq_core import tlps_pkg::*; #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic press_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  localparam int unsigned PW = ((COUNTER_BITS > 16) ? COUNTER_BITS : 16) + 1;

  typedef enum logic [2:0] {
    PhGo       = 3'd0,
    PhWarn     = 3'd1,
    PhStop     = 3'd2,
    PhPrepare  = 3'd3,
    PhWalkWarn = 3'd4,
    PhCross    = 3'd5,
    PhWalkEnd  = 3'd6
  } phase_e;

  function automatic logic [PW-1:0] clip_period(input logic [15:0] v);
    logic [PW-1:0] cap;
    logic [PW-1:0] v_ext;
    cap   = PW'(1) << COUNTER_BITS;
    v_ext = PW'(v);
    return (v_ext > cap) ? cap : v_ext;
  endfunction

  function automatic phase_e next_phase(input phase_e p);
    phase_e n;
    unique case (p)
      PhGo:       n = PhWarn;
      PhWarn:     n = PhStop;
      PhStop:     n = PhPrepare;
      PhWalkWarn: n = PhCross;
      PhCross:    n = PhWalkEnd;
      default:    n = PhGo;
    endcase
    return n;
  endfunction

  phase_e                  phase_q, phase_d, phase_eff;
  logic [COUNTER_BITS-1:0] tick_q, tick_d, tick_eff;
  logic [7:0]              blink_q, blink_d, blink_eff;
  logic [PW-1:0]           blink_period, steady_period, tick_next;
  logic                    blink_on, steady, period_end, blink_end;

  assign blink_period  = clip_period(cfg_i.blink_ticks);
  assign steady_period = clip_period(cfg_i.phase_ticks);

  always_comb begin
    phase_eff = phase_q;
    tick_eff  = tick_q;
    blink_eff = blink_q;
    if (press_i) begin
      unique case (phase_q) inside
        PhGo, PhWarn: begin
          phase_eff = PhWalkWarn;
          tick_eff  = '0;
          blink_eff = '0;
        end
        PhStop, PhPrepare: begin
          phase_eff = PhCross;
          tick_eff  = '0;
          blink_eff = '0;
        end
        default: ;
      endcase
    end
  end

  assign blink_on  = PW'(tick_eff) < (blink_period >> 1);
  assign tick_next = PW'(tick_eff) + PW'(1);

  always_comb begin
    res_o       = '0;
    res_o.phase = 3'(phase_eff);
    unique case (phase_eff)
      PhGo: begin
        res_o.car_green = 1'b1;
        res_o.walk_red  = 1'b1;
      end
      PhWarn: begin
        res_o.car_green  = 1'b1;
        res_o.car_yellow = blink_on;
        res_o.walk_red   = 1'b1;
      end
      PhStop: begin
        res_o.car_red  = 1'b1;
        res_o.walk_red = 1'b1;
      end
      PhPrepare: begin
        res_o.car_red    = 1'b1;
        res_o.car_yellow = blink_on;
        res_o.walk_red   = 1'b1;
      end
      PhWalkWarn: begin
        res_o.car_green   = 1'b1;
        res_o.walk_red    = 1'b1;
        res_o.car_yellow  = blink_on;
        res_o.walk_yellow = blink_on;
      end
      PhCross: begin
        res_o.car_red    = 1'b1;
        res_o.walk_green = 1'b1;
      end
      PhWalkEnd: begin
        res_o.car_red     = 1'b1;
        res_o.walk_green  = 1'b1;
        res_o.car_yellow  = blink_on;
        res_o.walk_yellow = blink_on;
      end
      default: ;
    endcase
  end

  always_comb begin
    steady = 1'b0;
    unique case (phase_eff) inside
      PhGo, PhStop, PhCross: steady = 1'b1;
      default:               steady = 1'b0;
    endcase
  end

  assign period_end = steady ? (tick_next >= steady_period) : (tick_next >= blink_period);
  assign blink_end  = ({1'b0, blink_eff} + 9'd1) >= {1'b0, cfg_i.blink_count};

  always_comb begin
    phase_d = phase_eff;
    tick_d  = tick_eff + COUNTER_BITS'(1);
    blink_d = blink_eff;
    if (period_end) begin
      tick_d = '0;
      if (steady || blink_end) begin
        blink_d = '0;
        phase_d = next_phase(phase_eff);
      end else begin
        blink_d = blink_eff + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhGo;
      tick_q  <= '0;
      blink_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      blink_q <= blink_d;
    end
  end

endmodule
